// ----- src/lfu_pkg.sv -----
// lfu_pkg: shared sizes, action codes and record types for the lfu anchor cache
// used by lfu_slot_mem, lfu_scan_unit and lfu_anchor_cache
package lfu_pkg;

  localparam int ENTRIES     = 16;
  localparam int ANCHOR_BITS = 64;
  localparam int USE_BITS    = 32;
  localparam int CNT_BITS    = 32;
  localparam int ID_BITS     = 64;
  localparam int TYPE_BITS   = 8;
  localparam int CAP_BITS    = 5;
  localparam int SLOT_BITS   = $clog2(ENTRIES);
  localparam int FILL_BITS   = $clog2(ENTRIES + 1);
  localparam int CMP_BITS    = (FILL_BITS > CAP_BITS) ? FILL_BITS : CAP_BITS;

  localparam logic [USE_BITS-1:0] USE_MAX = '1;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  localparam logic [2:0] ACT_GET   = 3'd0;
  localparam logic [2:0] ACT_PUT   = 3'd1;
  localparam logic [2:0] ACT_INVAL = 3'd2;
  localparam logic [2:0] ACT_CLEAR = 3'd3;
  localparam logic [2:0] ACT_STATS = 3'd4;

  // one stored slot, without its valid bit
  typedef struct packed {
    logic [ID_BITS-1:0]     id;
    logic [TYPE_BITS-1:0]   etype;
    logic [ANCHOR_BITS-1:0] anchor;
    logic [USE_BITS-1:0]    uses;
  } slot_rec_t;

  // what one pass over the slots found
  typedef struct packed {
    logic                   hit;
    logic [SLOT_BITS-1:0]   hit_idx;
    logic [ANCHOR_BITS-1:0] hit_anchor;
    logic [USE_BITS-1:0]    hit_uses;
    logic                   vic_ok;
    logic [SLOT_BITS-1:0]   vic_idx;
    logic [USE_BITS-1:0]    vic_uses;
    logic                   free_ok;
    logic [SLOT_BITS-1:0]   free_idx;
  } scan_res_t;

endpackage

// ----- src/lfu_slot_mem.sv -----
// lfu_slot_mem: slot storage (key, anchor, use count) with one write port
// and one registered read port; depends on lfu_pkg
module lfu_slot_mem (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [lfu_pkg::SLOT_BITS-1:0] rd_addr,
  output lfu_pkg::slot_rec_t        rd_data,
  input  logic                      wr_en,
  input  logic [lfu_pkg::SLOT_BITS-1:0] wr_addr,
  input  lfu_pkg::slot_rec_t        wr_data
);
  import lfu_pkg::*;

  slot_rec_t mem_r [ENTRIES];
  slot_rec_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/lfu_scan_unit.sv -----
// lfu_scan_unit: shared compare unit stepped once per slot, tracks key match,
// least-used victim and lowest free slot; depends on lfu_pkg
module lfu_scan_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          step,
  input  logic [lfu_pkg::SLOT_BITS-1:0] slot_idx,
  input  logic                          slot_valid,
  input  lfu_pkg::slot_rec_t            rec,
  input  logic [lfu_pkg::ID_BITS-1:0]   key_id,
  input  logic [lfu_pkg::TYPE_BITS-1:0] key_type,
  output lfu_pkg::scan_res_t            res
);
  import lfu_pkg::*;

  scan_res_t res_r;
  scan_res_t res_nxt;
  logic      key_eq;
  logic      use_lt;

  // one key compare and one use-count compare per step
  assign key_eq = (rec.id == key_id) && (rec.etype == key_type);
  assign use_lt = rec.uses < res_r.vic_uses;

  always_comb begin
    res_nxt = res_r;
    if (start) begin
      res_nxt.hit     = 1'b0;
      res_nxt.vic_ok  = 1'b0;
      res_nxt.free_ok = 1'b0;
    end else if (step) begin
      // first valid slot with the key
      if (slot_valid && key_eq && !res_r.hit) begin
        res_nxt.hit        = 1'b1;
        res_nxt.hit_idx    = slot_idx;
        res_nxt.hit_anchor = rec.anchor;
        res_nxt.hit_uses   = rec.uses;
      end
      // strictly lower count wins, so ties stay with the lowest slot
      if (slot_valid && (!res_r.vic_ok || use_lt)) begin
        res_nxt.vic_ok   = 1'b1;
        res_nxt.vic_idx  = slot_idx;
        res_nxt.vic_uses = rec.uses;
      end
      // lowest empty slot
      if (!slot_valid && !res_r.free_ok) begin
        res_nxt.free_ok  = 1'b1;
        res_nxt.free_idx = slot_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.hit     <= 1'b0;
      res_r.vic_ok  <= 1'b0;
      res_r.free_ok <= 1'b0;
    end else begin
      res_r.hit     <= res_nxt.hit;
      res_r.vic_ok  <= res_nxt.vic_ok;
      res_r.free_ok <= res_nxt.free_ok;
    end
    res_r.hit_idx    <= res_nxt.hit_idx;
    res_r.hit_anchor <= res_nxt.hit_anchor;
    res_r.hit_uses   <= res_nxt.hit_uses;
    res_r.vic_idx    <= res_nxt.vic_idx;
    res_r.vic_uses   <= res_nxt.vic_uses;
    res_r.free_idx   <= res_nxt.free_idx;
  end

  assign res = res_r;

endmodule

// ----- src/lfu_anchor_cache.sv -----
// lfu_anchor_cache: top level, sequencer, valid bits, fill count and counters
// depends on lfu_pkg, lfu_slot_mem and lfu_scan_unit
//
// Usage:
//   The input channel (in_valid / in_stall) takes one transaction: an action
//   (get, put, invalidate, clear, reset counters) with key and anchor word.
//   Every transaction returns exactly one result on the output channel
//   (out_valid / out_stall): found, anchor word, hit and miss counters.
//   Get, put and invalidate walk all ENTRIES slots through one memory read
//   port and one shared compare unit, one slot per cycle. Clear, counter
//   reset and unused codes skip the walk.
//   in_stall is high while an item is in work. A finished result sits in the
//   output register; if the receiver stalls it holds there and the block
//   finishes its next item up to the point of handing over, then waits.
//   The capacity register is written via cfg_valid / cfg_ready, by the user only
//   while the block is idle, not enforced by the block; cfg_ready is always high.
//   Reset (rst_n low, synchronous) empties all slots, zeroes the counters,
//   sets capacity to 16 and drops out_valid. No clearing pass is needed.
module lfu_anchor_cache (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_action,
  input  logic [lfu_pkg::ID_BITS-1:0]   in_entity_id,
  input  logic [lfu_pkg::TYPE_BITS-1:0] in_entity_type,
  input  logic [63:0]                   in_anchor_in,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [63:0]                   out_anchor_out,
  output logic [lfu_pkg::CNT_BITS-1:0]  out_hits_so_far,
  output logic [lfu_pkg::CNT_BITS-1:0]  out_misses_so_far,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lfu_pkg::CAP_BITS-1:0]  cfg_wdata
);
  import lfu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]             act_r;
  logic [ID_BITS-1:0]     id_r;
  logic [TYPE_BITS-1:0]   type_r;
  logic [ANCHOR_BITS-1:0] anchor_r;

  logic [CAP_BITS-1:0]    cap_r, cap_nxt;
  logic [ENTRIES-1:0]     valid_r, valid_nxt;
  logic [FILL_BITS-1:0]   fill_r, fill_nxt;
  logic [CNT_BITS-1:0]    hits_r, hits_nxt;
  logic [CNT_BITS-1:0]    misses_r, misses_nxt;
  logic                   found_r, found_nxt;
  logic [ANCHOR_BITS-1:0] word_r, word_nxt;

  logic [SLOT_BITS:0]     scan_cnt_r, scan_cnt_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [SLOT_BITS-1:0]   rd_slot_r;
  logic                   rd_bit_r;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r;
  logic [ANCHOR_BITS-1:0] out_anchor_r;
  logic [CNT_BITS-1:0]    out_hits_r;
  logic [CNT_BITS-1:0]    out_misses_r;

  logic                   in_acc;
  logic                   rd_en;
  logic [SLOT_BITS-1:0]   rd_addr;
  slot_rec_t              rd_data;
  logic                   wr_en;
  logic [SLOT_BITS-1:0]   wr_addr;
  slot_rec_t              wr_data;
  scan_res_t              scan;
  logic                   scan_start;

  logic [CMP_BITS-1:0]    cap_eff;
  logic                   evict;
  logic [SLOT_BITS-1:0]   ins_idx;
  logic                   load_out;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // slot walk: one read issued per cycle, registered data arrives in the next cycle
  assign rd_en      = (state_r == ST_SCAN) && (scan_cnt_r < (SLOT_BITS+1)'(ENTRIES));
  assign rd_addr    = scan_cnt_r[SLOT_BITS-1:0];
  assign scan_start = in_acc;

  lfu_slot_mem u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lfu_scan_unit u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (scan_start),
    .step       (rd_vld_r),
    .slot_idx   (rd_slot_r),
    .slot_valid (rd_bit_r),
    .rec        (rd_data),
    .key_id     (id_r),
    .key_type   (type_r),
    .res        (scan)
  );

  // capacity clamped to 1..ENTRIES
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CMP_BITS'(1);
    end else if (CMP_BITS'(cap_r) > CMP_BITS'(ENTRIES)) begin
      cap_eff = CMP_BITS'(ENTRIES);
    end else begin
      cap_eff = CMP_BITS'(cap_r);
    end
  end

  // insert slot: lowest empty slot once the victim is gone
  assign evict = CMP_BITS'(fill_r) >= cap_eff;
  always_comb begin
    if (!evict) begin
      ins_idx = scan.free_idx;
    end else if (scan.free_ok && (scan.free_idx < scan.vic_idx)) begin
      ins_idx = scan.free_idx;
    end else begin
      ins_idx = scan.vic_idx;
    end
  end

  // slot write on a put
  always_comb begin
    wr_en          = (state_r == ST_UPDATE) && (act_r == ACT_PUT);
    wr_addr        = scan.hit ? scan.hit_idx : ins_idx;
    wr_data.id     = id_r;
    wr_data.etype  = type_r;
    wr_data.anchor = anchor_r;
    if (!scan.hit) begin
      wr_data.uses = USE_BITS'(1);
    end else if (scan.hit_uses == USE_MAX) begin
      wr_data.uses = scan.hit_uses;
    end else begin
      wr_data.uses = scan.hit_uses + USE_BITS'(1);
    end
  end

  assign load_out = (state_r == ST_RESP) && (!out_valid_r || !out_stall);

  // sequencer and state updates
  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cap_r;
    valid_nxt     = valid_r;
    fill_nxt      = fill_r;
    hits_nxt      = hits_r;
    misses_nxt    = misses_r;
    found_nxt     = found_r;
    word_nxt      = word_r;
    scan_cnt_nxt  = scan_cnt_r;
    rd_vld_nxt    = rd_en;
    out_valid_nxt = out_valid_r;

    if (cfg_valid && cfg_ready) begin
      cap_nxt = cfg_wdata;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          scan_cnt_nxt = '0;
          found_nxt    = 1'b0;
          word_nxt     = '0;
          if ((in_action == ACT_GET) || (in_action == ACT_PUT) ||
              (in_action == ACT_INVAL)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_UPDATE;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          scan_cnt_nxt = scan_cnt_r + (SLOT_BITS+1)'(1);
        end
        if (rd_vld_r && (rd_slot_r == SLOT_BITS'(ENTRIES - 1))) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_RESP;
        case (act_r)
          ACT_GET: begin
            if (scan.hit) begin
              found_nxt = 1'b1;
              word_nxt  = scan.hit_anchor;
              if (hits_r != CNT_MAX) begin
                hits_nxt = hits_r + CNT_BITS'(1);
              end
            end else if (misses_r != CNT_MAX) begin
              misses_nxt = misses_r + CNT_BITS'(1);
            end
          end
          ACT_PUT: begin
            if (!scan.hit) begin
              if (evict) begin
                valid_nxt[scan.vic_idx] = 1'b0;
              end else begin
                fill_nxt = fill_r + FILL_BITS'(1);
              end
              valid_nxt[ins_idx] = 1'b1;
            end
          end
          ACT_INVAL: begin
            if (scan.hit) begin
              valid_nxt[scan.hit_idx] = 1'b0;
              fill_nxt = fill_r - FILL_BITS'(1);
            end
          end
          ACT_CLEAR: begin
            valid_nxt = '0;
            fill_nxt  = '0;
          end
          ACT_STATS: begin
            hits_nxt   = '0;
            misses_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      ST_RESP: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state, control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      fill_r      <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      scan_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      valid_r     <= valid_nxt;
      fill_r      <= fill_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    found_r   <= found_nxt;
    word_r    <= word_nxt;
    rd_slot_r <= rd_addr;
    rd_bit_r  <= valid_r[rd_addr];
    if (in_acc) begin
      act_r    <= in_action;
      id_r     <= in_entity_id;
      type_r   <= in_entity_type;
      anchor_r <= in_anchor_in[ANCHOR_BITS-1:0];
    end
    if (load_out) begin
      out_found_r  <= found_r;
      out_anchor_r <= word_r;
      out_hits_r   <= hits_r;
      out_misses_r <= misses_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_anchor_out    = 64'(out_anchor_r);
  assign out_hits_so_far   = out_hits_r;
  assign out_misses_so_far = out_misses_r;

  // fill count tracks the valid bits
  a_fill_matches : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == FILL_BITS'($countones(valid_r)))
    else $error("fill count out of step with valid bits");

  // an insert without eviction always has an empty slot
  a_free_slot : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) && (act_r == ACT_PUT) && !scan.hit && !evict |-> scan.free_ok)
    else $error("insert without eviction found no empty slot");

  // an eviction always has a victim
  a_victim : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) && (act_r == ACT_PUT) && !scan.hit && evict |-> scan.vic_ok)
    else $error("eviction without a victim");

  // a new result is loaded only after the previous one left
  a_out_load : assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

endmodule

// ----- test/tb_lfu_anchor_cache.sv -----
// tb_lfu_anchor_cache: self-checking bench for the lfu anchor cache, with directed and random
// transactions over several capacity settings, each checked against an in-bench cache model
// depends on lfu_pkg and lfu_anchor_cache
`timescale 1ns / 1ps

module tb_lfu_anchor_cache;
  import lfu_pkg::*;

  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int KEY_POOL    = 24;
  localparam int LONG_HOLD   = 200;
  localparam int HOLD_EVERY  = 600;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [2:0]           action;
    logic [ID_BITS-1:0]   id;
    logic [TYPE_BITS-1:0] etype;
    logic [63:0]          anchor;
  } cache_op_t;

  typedef struct packed {
    logic                found;
    logic [63:0]         anchor;
    logic [CNT_BITS-1:0] hits;
    logic [CNT_BITS-1:0] misses;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_action = '0;
  logic [ID_BITS-1:0] in_entity_id = '0;
  logic [TYPE_BITS-1:0] in_entity_type = '0;
  logic [63:0] in_anchor_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_found;
  logic [63:0] out_anchor_out;
  logic [CNT_BITS-1:0] out_hits_so_far;
  logic [CNT_BITS-1:0] out_misses_so_far;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_BITS-1:0] cfg_wdata = '0;

  lfu_anchor_cache dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_entity_id      (in_entity_id),
    .in_entity_type    (in_entity_type),
    .in_anchor_in      (in_anchor_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_anchor_out    (out_anchor_out),
    .out_hits_so_far   (out_hits_so_far),
    .out_misses_so_far (out_misses_so_far),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  // bench-side copy of the cache
  logic                   held_valid [ENTRIES];
  logic [ID_BITS-1:0]     held_id    [ENTRIES];
  logic [TYPE_BITS-1:0]   held_type  [ENTRIES];
  logic [ANCHOR_BITS-1:0] held_anchor[ENTRIES];
  logic [USE_BITS-1:0]    held_uses  [ENTRIES];
  logic [CNT_BITS-1:0]    hit_tally;
  logic [CNT_BITS-1:0]    miss_tally;
  logic [CAP_BITS-1:0]    cap_reg;

  cache_op_t pending_ops[$];
  reply_t    expected_replies[$];

  logic [ID_BITS-1:0]   pool_id  [KEY_POOL];
  logic [TYPE_BITS-1:0] pool_type[KEY_POOL];

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  logic out_waiting = 1'b0;
  logic cfg_took = 1'b0;
  int   tx_gap_max = 11;
  int   rx_stall_max = 11;
  int   results_seen = 0;
  int   err_count = 0;
  int   n_items = 0;
  int   n_found = 0;
  int   n_evicted = 0;
  int   cycle_count = 0;

  function automatic void cache_reset();
    for (int i = 0; i < ENTRIES; i++) held_valid[i] = 1'b0;
    hit_tally  = '0;
    miss_tally = '0;
    cap_reg    = CAP_RESET;
  endfunction

  function automatic int slot_of(logic [ID_BITS-1:0] id, logic [TYPE_BITS-1:0] etype);
    for (int i = 0; i < ENTRIES; i++)
      if (held_valid[i] && held_id[i] == id && held_type[i] == etype) return i;
    return -1;
  endfunction

  // apply one transaction to the bench cache and return the reply it should give
  function automatic reply_t cache_apply(cache_op_t op);
    reply_t r;
    int s;
    int fill;
    int lim;
    int victim;
    r = '0;
    n_items++;
    case (op.action)
      ACT_GET: begin
        s = slot_of(op.id, op.etype);
        if (s >= 0) begin
          r.found  = 1'b1;
          r.anchor = 64'(held_anchor[s]);
          n_found++;
          if (hit_tally != CNT_MAX) hit_tally++;
        end else if (miss_tally != CNT_MAX) begin
          miss_tally++;
        end
      end
      ACT_PUT: begin
        s = slot_of(op.id, op.etype);
        if (s >= 0) begin
          held_anchor[s] = op.anchor[ANCHOR_BITS-1:0];
          if (held_uses[s] != USE_MAX) held_uses[s]++;
        end else begin
          fill = 0;
          for (int i = 0; i < ENTRIES; i++) if (held_valid[i]) fill++;
          lim = (cap_reg == 0) ? 1 : (int'(cap_reg) > ENTRIES) ? ENTRIES : int'(cap_reg);
          // evict the least used entry, lowest slot on a tie
          if (fill >= lim && fill > 0) begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++)
              if (held_valid[i] && (victim < 0 || held_uses[i] < held_uses[victim])) victim = i;
            held_valid[victim] = 1'b0;
            n_evicted++;
          end
          // new key lands in the lowest free slot
          for (int i = 0; i < ENTRIES; i++) begin
            if (!held_valid[i]) begin
              held_valid[i]  = 1'b1;
              held_id[i]     = op.id;
              held_type[i]   = op.etype;
              held_anchor[i] = op.anchor[ANCHOR_BITS-1:0];
              held_uses[i]   = USE_BITS'(1);
              break;
            end
          end
        end
      end
      ACT_INVAL: begin
        s = slot_of(op.id, op.etype);
        if (s >= 0) held_valid[s] = 1'b0;
      end
      ACT_CLEAR: for (int i = 0; i < ENTRIES; i++) held_valid[i] = 1'b0;
      ACT_STATS: begin
        hit_tally  = '0;
        miss_tally = '0;
      end
      default: ;
    endcase
    r.hits   = hit_tally;
    r.misses = miss_tally;
    return r;
  endfunction

  // sample handshakes, predict accepted transactions, check results
  always @(posedge clk) begin : watch
    reply_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_lfu_anchor_cache: done, errors");
      $finish;
    end else if (!rst_n) begin
      in_took     <= 1'b0;
      out_took    <= 1'b0;
      out_waiting <= 1'b0;
      cfg_took    <= 1'b0;
    end else begin
      in_took     <= in_valid && !in_stall;
      out_took    <= out_valid && !out_stall;
      out_waiting <= out_valid && out_stall;
      cfg_took    <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) cap_reg = cfg_wdata;
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_replies.size() == 0) begin
          $error("result transaction with nothing expected");
          err_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_found);
            err_count++;
          end
          if (out_anchor_out !== want.anchor) begin
            $error("anchor_out: expected %h, got %h", want.anchor, out_anchor_out);
            err_count++;
          end
          if (out_hits_so_far !== want.hits) begin
            $error("hits_so_far: expected %0d, got %0d", want.hits, out_hits_so_far);
            err_count++;
          end
          if (out_misses_so_far !== want.misses) begin
            $error("misses_so_far: expected %0d, got %0d", want.misses, out_misses_so_far);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_replies.insert(expected_replies.size(),
          cache_apply({in_action, in_entity_id, in_entity_type, in_anchor_in}));
    end
  end

  // input driver: random gap before each transaction, payload held while stalled
  always @(negedge clk) begin : drive_in
    cache_op_t op;
    int tx_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_took) tx_gap = $urandom_range(tx_gap_max, 0);
      if (in_valid && !in_took) begin
        // stalled, keep offering the same transaction
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        in_action      <= op.action;
        in_entity_id   <= op.id;
        in_entity_type <= op.etype;
        in_anchor_in   <= op.anchor;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: random stall per result, plus a long hold now and then
  always @(negedge clk) begin : drive_out
    int rx_wait;
    int rx_hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (out_took) begin
        rx_wait = $urandom_range(rx_stall_max, 0);
        if (results_seen % HOLD_EVERY == 0) rx_hold = LONG_HOLD;
      end else if (rx_wait > 0 && out_waiting) begin
        rx_wait--;
      end
      if (rx_hold > 0) rx_hold--;
      out_stall <= (rx_hold > 0) || (rx_wait > 0);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_op(logic [2:0] action, logic [ID_BITS-1:0] id,
                          logic [TYPE_BITS-1:0] etype, logic [63:0] anchor);
    pending_ops.insert(pending_ops.size(), {action, id, etype, anchor});
  endtask

  // fresh key set, with some near misses on id or type
  task automatic refresh_keys();
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_id[i]   = rand64();
      pool_type[i] = TYPE_BITS'($urandom);
      if (i > 0 && $urandom_range(3, 0) == 0) begin
        pool_id[i] = pool_id[i-1];
      end else if (i > 0 && $urandom_range(7, 0) == 0) begin
        pool_type[i] = pool_type[i-1];
        pool_id[i]   = pool_id[i-1] ^ (64'd1 << $urandom_range(63, 0));
      end
    end
  endtask

  // random transactions on a key span, unused codes counted toward n
  task automatic queue_random(int n, int span);
    int done;
    int k;
    int roll;
    logic [2:0] action;
    logic [ID_BITS-1:0] id;
    logic [TYPE_BITS-1:0] etype;
    done = 0;
    while (done < n) begin
      k = $urandom_range(1, 0) ? $urandom_range(3, 0) : $urandom_range(span - 1, 0);
      id    = pool_id[k];
      etype = pool_type[k];
      if ($urandom_range(99, 0) < 8) begin
        id    = rand64();
        etype = TYPE_BITS'($urandom);
      end
      roll = $urandom_range(99, 0);
      if (roll < 40)      action = ACT_GET;
      else if (roll < 75) action = ACT_PUT;
      else if (roll < 87) action = ACT_INVAL;
      else if (roll < 89) action = ACT_CLEAR;
      else if (roll < 93) action = ACT_STATS;
      else                action = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
      done++;
      queue_op(action, id, etype, rand64());
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || expected_replies.size() != 0 || in_valid)
      @(negedge clk);
  endtask

  // only while idle: drain, let the last item finish, then write
  task automatic write_capacity(logic [CAP_BITS-1:0] value);
    wait_drained();
    repeat (ENTRIES + 6) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_wdata <= value;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [CAP_BITS-1:0] cap, int tx_max, int rx_max, int n, int span);
    write_capacity(cap);
    tx_gap_max   = tx_max;
    rx_stall_max = rx_max;
    refresh_keys();
    queue_random(n, span);
  endtask

  initial begin
    logic [ID_BITS-1:0] key_b;
    logic [ID_BITS-1:0] key_c;
    cache_reset();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every action, overwrite, near-miss key, unused codes
    key_b = '1;
    key_c = '0;
    queue_op(ACT_GET,   64'h0123_4567_89ab_cdef, 8'h5a, '0);
    queue_op(ACT_PUT,   64'h0123_4567_89ab_cdef, 8'h5a, '1);
    queue_op(ACT_GET,   64'h0123_4567_89ab_cdef, 8'h5a, '0);
    queue_op(ACT_PUT,   64'h0123_4567_89ab_cdef, 8'h5a, '0);
    queue_op(ACT_GET,   64'h0123_4567_89ab_cdef, 8'h5a, '1);
    queue_op(ACT_GET,   64'h0123_4567_89ab_cdef, 8'ha5, '0);
    queue_op(ACT_PUT,   key_b, 8'hff, 64'h5555_5555_5555_5555);
    queue_op(ACT_PUT,   key_c, 8'h00, 64'haaaa_aaaa_aaaa_aaaa);
    queue_op(ACT_GET,   key_b, 8'hff, '0);
    queue_op(ACT_GET,   key_c, 8'h00, '0);
    queue_op(ACT_INVAL, key_b, 8'hff, '0);
    queue_op(ACT_GET,   key_b, 8'hff, '0);
    queue_op(ACT_INVAL, key_b, 8'hff, '0);
    queue_op(ACT_SPARE_LO,        rand64(), 8'h3c, rand64());
    queue_op(ACT_SPARE_LO + 3'd1, rand64(), 8'hc3, rand64());
    queue_op(ACT_SPARE_HI,        rand64(), 8'h81, rand64());
    queue_op(ACT_STATS, key_c, 8'h00, '0);
    queue_op(ACT_GET,   key_c, 8'h00, '0);
    queue_op(ACT_CLEAR, key_c, 8'h00, '0);
    queue_op(ACT_GET,   key_c, 8'h00, '0);
    queue_op(ACT_GET,   64'h0123_4567_89ab_cdef, 8'h5a, '0);

    refresh_keys();
    queue_random(300, KEY_POOL);
    // capacity above the slot count, no idling
    run_phase(CAP_BITS'(31), 0, 0, 200, KEY_POOL);
    // capacity dropped well below the current fill
    run_phase(CAP_BITS'(3), 11, 0, 250, 8);
    // capacity zero acts as one
    run_phase(CAP_BITS'(0), 0, 11, 150, 4);
    run_phase(CAP_BITS'(1), 11, 11, 150, 4);
    run_phase(CAP_BITS'(ENTRIES), 11, 11, 300, KEY_POOL);
    run_phase(CAP_BITS'(7), 5, 11, 300, 12);

    wait_drained();
    repeat (ENTRIES + 8) @(negedge clk);
    $display("covered %0d transactions over capacities 16 31 3 0 1 16 7", n_items);
    $display("  with %0d get hits and %0d evictions", n_found, n_evicted);
    if (err_count == 0) begin
      $display("tb_lfu_anchor_cache: done, clean");
    end else begin
      $display("tb_lfu_anchor_cache: done, errors");
    end
    $finish;
  end

endmodule
